### hw/rtl/latency_histogram_binning_assert.svh
// Assertion macros shared by the latency histogram RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef LATENCY_HISTOGRAM_BINNING_ASSERT_SVH
`define LATENCY_HISTOGRAM_BINNING_ASSERT_SVH

// Checks that cons holds in the cycle after ante.
`define LHB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks that expr holds at every clock edge outside reset.
`define LHB_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

### hw/rtl/lhb_pkg.sv
// Package for the latency histogram: sizes, beat types, function codes
// and the fixed bucket bound table. No dependencies.
package lhb_pkg;

  localparam int NUM_BUCKETS = 19;
  localparam int COUNT_WIDTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int SUM_WIDTH   = 64;
  localparam int SEL_WIDTH   = 5;
  localparam int HIT_WIDTH   = 5;
  localparam int DATA_WIDTH  = 64;

  typedef enum logic [1:0] {
    FUNC_OBSERVE = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_CLEAR   = 2'd2
  } func_t;

  localparam logic [SEL_WIDTH-1:0] SEL_OVERFLOW = SEL_WIDTH'(NUM_BUCKETS);
  localparam logic [SEL_WIDTH-1:0] SEL_COUNT    = SEL_WIDTH'(NUM_BUCKETS + 1);
  localparam logic [SEL_WIDTH-1:0] SEL_MIN      = SEL_WIDTH'(NUM_BUCKETS + 2);
  localparam logic [SEL_WIDTH-1:0] SEL_MAX      = SEL_WIDTH'(NUM_BUCKETS + 3);
  localparam logic [SEL_WIDTH-1:0] SEL_SUM      = SEL_WIDTH'(NUM_BUCKETS + 4);

  localparam logic [HIT_WIDTH-1:0] HIT_OVERFLOW = HIT_WIDTH'(NUM_BUCKETS);

  typedef struct packed {
    func_t                  func;
    logic [VALUE_WIDTH-1:0] lat_ns;
    logic [SEL_WIDTH-1:0]   read_select;
  } in_beat_t;

  typedef struct packed {
    logic [HIT_WIDTH-1:0]  bucket_hit;
    logic [DATA_WIDTH-1:0] read_data;
  } out_beat_t;

  // Decoded operation for the cells and the statistics unit.
  typedef struct packed {
    logic                 observe;
    logic                 read;
    logic                 clear;
    logic [SEL_WIDTH-1:0] read_select;
  } cell_ctl_t;

  // Inclusive upper bound of bucket k; slots past the table return all ones.
  function automatic logic [VALUE_WIDTH-1:0] bucket_bound(input int k);
    logic [VALUE_WIDTH-1:0] b;
    case (k)
      0:       b = VALUE_WIDTH'(64'd1000);
      1:       b = VALUE_WIDTH'(64'd2500);
      2:       b = VALUE_WIDTH'(64'd5000);
      3:       b = VALUE_WIDTH'(64'd10000);
      4:       b = VALUE_WIDTH'(64'd25000);
      5:       b = VALUE_WIDTH'(64'd50000);
      6:       b = VALUE_WIDTH'(64'd100000);
      7:       b = VALUE_WIDTH'(64'd250000);
      8:       b = VALUE_WIDTH'(64'd500000);
      9:       b = VALUE_WIDTH'(64'd1000000);
      10:      b = VALUE_WIDTH'(64'd2500000);
      11:      b = VALUE_WIDTH'(64'd5000000);
      12:      b = VALUE_WIDTH'(64'd10000000);
      13:      b = VALUE_WIDTH'(64'd25000000);
      14:      b = VALUE_WIDTH'(64'd50000000);
      15:      b = VALUE_WIDTH'(64'd100000000);
      16:      b = VALUE_WIDTH'(64'd250000000);
      17:      b = VALUE_WIDTH'(64'd500000000);
      18:      b = VALUE_WIDTH'(64'd1000000000);
      default: b = '1;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/lhb_cell.sv
// One histogram bucket: its bound compare and its saturating counter.
// Cells are chained on the compare flag, hit index and read data. Uses lhb_pkg.
module lhb_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lhb_pkg::cell_ctl_t                 ctl_i,
  input  logic [lhb_pkg::VALUE_WIDTH-1:0]    value_i,
  input  logic [lhb_pkg::VALUE_WIDTH-1:0]    bound_i,
  input  logic [lhb_pkg::HIT_WIDTH-1:0]      idx_i,
  input  logic                               le_prev_i,
  input  logic [lhb_pkg::HIT_WIDTH-1:0]      hidx_i,
  input  logic [lhb_pkg::COUNT_WIDTH-1:0]    rd_i,
  output logic                               le_o,
  output logic                               hit_o,
  output logic [lhb_pkg::HIT_WIDTH-1:0]      hidx_o,
  output logic [lhb_pkg::COUNT_WIDTH-1:0]    rd_o
);

  logic [lhb_pkg::COUNT_WIDTH-1:0] count_r;
  logic [lhb_pkg::COUNT_WIDTH-1:0] count_nxt;
  logic                            sel_me;

  // Bounds ascend, so the first bucket at or above the value is the one whose
  // left neighbor's bound is below it.
  assign le_o   = (value_i <= bound_i);
  assign hit_o  = le_o && !le_prev_i;
  assign hidx_o = hidx_i | (hit_o ? idx_i : '0);
  assign sel_me = (ctl_i.read_select == lhb_pkg::SEL_WIDTH'(idx_i));
  assign rd_o   = rd_i | (sel_me ? count_r : '0);

  always_comb begin
    count_nxt = count_r;
    if (ctl_i.clear) begin
      count_nxt = '0;
    end else if (ctl_i.observe && hit_o && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

### hw/rtl/lhb_stats.sv
// Overflow counter and running statistics: count, min, max and saturating sum.
// Also selects the statistic for reads beyond the buckets. Uses lhb_pkg.
module lhb_stats (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lhb_pkg::cell_ctl_t                ctl_i,
  input  logic [lhb_pkg::VALUE_WIDTH-1:0]   value_i,
  input  logic                              overflow_i,
  output logic [lhb_pkg::DATA_WIDTH-1:0]    rd_o,
  output logic                              empty_o
);

  logic [lhb_pkg::COUNT_WIDTH-1:0] ovf_r, ovf_nxt;
  logic [lhb_pkg::COUNT_WIDTH-1:0] samples_r, samples_nxt;
  logic [lhb_pkg::VALUE_WIDTH-1:0] min_r, min_nxt;
  logic [lhb_pkg::VALUE_WIDTH-1:0] max_r, max_nxt;
  logic [lhb_pkg::SUM_WIDTH-1:0]   sum_r, sum_nxt;
  logic [lhb_pkg::SUM_WIDTH:0]     sum_add;

  assign sum_add = {1'b0, sum_r} + (lhb_pkg::SUM_WIDTH + 1)'(value_i);
  assign empty_o = (samples_r == '0);

  always_comb begin
    ovf_nxt     = ovf_r;
    samples_nxt = samples_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    sum_nxt     = sum_r;
    if (ctl_i.clear) begin
      ovf_nxt     = '0;
      samples_nxt = '0;
      min_nxt     = '1;
      max_nxt     = '0;
      sum_nxt     = '0;
    end else if (ctl_i.observe) begin
      if (overflow_i && (ovf_r != '1)) begin
        ovf_nxt = ovf_r + 1'b1;
      end
      if (samples_r != '1) begin
        samples_nxt = samples_r + 1'b1;
      end
      if (value_i < min_r) begin
        min_nxt = value_i;
      end
      if (value_i > max_r) begin
        max_nxt = value_i;
      end
      // A carry out of the top bit means the sum has passed its maximum.
      sum_nxt = sum_add[lhb_pkg::SUM_WIDTH] ? '1 : sum_add[lhb_pkg::SUM_WIDTH-1:0];
    end
  end

  always_comb begin
    case (ctl_i.read_select)
      lhb_pkg::SEL_OVERFLOW: rd_o = lhb_pkg::DATA_WIDTH'(ovf_r);
      lhb_pkg::SEL_COUNT:    rd_o = lhb_pkg::DATA_WIDTH'(samples_r);
      lhb_pkg::SEL_MIN:      rd_o = empty_o ? '0 : lhb_pkg::DATA_WIDTH'(min_r);
      lhb_pkg::SEL_MAX:      rd_o = empty_o ? '0 : lhb_pkg::DATA_WIDTH'(max_r);
      lhb_pkg::SEL_SUM:      rd_o = lhb_pkg::DATA_WIDTH'(sum_r);
      default:               rd_o = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r     <= '0;
      samples_r <= '0;
      min_r     <= '1;
      max_r     <= '0;
      sum_r     <= '0;
    end else begin
      ovf_r     <= ovf_nxt;
      samples_r <= samples_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      sum_r     <= sum_nxt;
    end
  end

endmodule

### hw/rtl/latency_histogram_binning.sv
// Channel  | Direction | Beat type           | Handshake
// in_      | input     | lhb_pkg::in_beat_t  | in_valid / in_ready
// out_     | output    | lhb_pkg::out_beat_t | out_valid / out_ready
//
// Each item is decoded, applied to the bucket cells and statistics, and its
// result lands in the output register at the edge that accepts it.
// One item per cycle while the output drains, set by one bound compare per cell.
// in_ready is high whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous) zeroes all counters and sets the minimum to
// all ones; it needs no clearing pass.
// Top level of the latency histogram. Uses lhb_pkg, lhb_cell, lhb_stats and
// the assertion macros in latency_histogram_binning_assert.svh.
`include "latency_histogram_binning_assert.svh"

module latency_histogram_binning (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lhb_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lhb_pkg::out_beat_t  out_data
);

  localparam int NB = lhb_pkg::NUM_BUCKETS;

  logic                            in_fire;
  lhb_pkg::cell_ctl_t              ctl;
  logic [NB:0]                     le_chain;
  logic [NB-1:0]                   hit_vec;
  logic [lhb_pkg::HIT_WIDTH-1:0]   hidx_chain [NB+1];
  logic [lhb_pkg::COUNT_WIDTH-1:0] rd_chain [NB+1];
  logic [lhb_pkg::DATA_WIDTH-1:0]  stat_rd;
  logic                            stat_empty;
  logic                            overflow;
  logic                            out_valid_r, out_valid_nxt;
  lhb_pkg::out_beat_t              out_data_r, out_data_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    ctl             = '0;
    ctl.read_select = in_data.read_select;
    if (in_fire) begin
      case (in_data.func)
        lhb_pkg::FUNC_OBSERVE: ctl.observe = 1'b1;
        lhb_pkg::FUNC_READ:    ctl.read    = 1'b1;
        lhb_pkg::FUNC_CLEAR:   ctl.clear   = 1'b1;
        default:               ctl         = '0;
      endcase
    end
  end

  assign le_chain[0]   = 1'b0;
  assign hidx_chain[0] = '0;
  assign rd_chain[0]   = '0;

  for (genvar k = 0; k < NB; k++) begin : g_cell
    lhb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .value_i   (in_data.lat_ns),
      .bound_i   (lhb_pkg::bucket_bound(k)),
      .idx_i     (lhb_pkg::HIT_WIDTH'(k)),
      .le_prev_i (le_chain[k]),
      .hidx_i    (hidx_chain[k]),
      .rd_i      (rd_chain[k]),
      .le_o      (le_chain[k+1]),
      .hit_o     (hit_vec[k]),
      .hidx_o    (hidx_chain[k+1]),
      .rd_o      (rd_chain[k+1])
    );
  end

  // No cell at or above the value means it belongs to the overflow counter.
  assign overflow = !le_chain[NB];

  lhb_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl),
    .value_i    (in_data.lat_ns),
    .overflow_i (overflow),
    .rd_o       (stat_rd),
    .empty_o    (stat_empty)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (ctl.observe) begin
        out_data_nxt.bucket_hit = overflow ? lhb_pkg::HIT_OVERFLOW : hidx_chain[NB];
      end else if (ctl.read) begin
        if (in_data.read_select < lhb_pkg::SEL_OVERFLOW) begin
          out_data_nxt.read_data = lhb_pkg::DATA_WIDTH'(rd_chain[NB]);
        end else begin
          out_data_nxt.read_data = stat_rd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LHB_ASSERT_ALWAYS(a_single_bucket, $onehot0(hit_vec), "more than one bucket cell hit")
  `LHB_ASSERT_NEXT(a_observe_no_data, ctl.observe, out_data_r.read_data == '0, "observe beat carried read data")
  `LHB_ASSERT_NEXT(a_clear_empties, ctl.clear, stat_empty && (out_data_r == '0), "clear left statistics or a nonzero result")
  `LHB_ASSERT_NEXT(a_result_valid, in_fire, out_valid_r, "accepted beat produced no result")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for latency_histogram_binning: random and directed observe, read
// and clear beats, checked against a bucket/statistics predictor. Uses lhb_pkg.
module tb;

  localparam lhb_pkg::func_t FUNC_SPARE = lhb_pkg::func_t'(2'b11);
  localparam int STALL_LIMIT = 5000;
  localparam logic [lhb_pkg::VALUE_WIDTH-1:0] BOUND_NS [lhb_pkg::NUM_BUCKETS] = '{
    32'd1000, 32'd2500, 32'd5000, 32'd10000, 32'd25000, 32'd50000, 32'd100000,
    32'd250000, 32'd500000, 32'd1000000, 32'd2500000, 32'd5000000, 32'd10000000,
    32'd25000000, 32'd50000000, 32'd100000000, 32'd250000000, 32'd500000000,
    32'd1000000000
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  lhb_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lhb_pkg::out_beat_t out_data;

  latency_histogram_binning u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predicted histogram state.
  logic [lhb_pkg::COUNT_WIDTH-1:0] bin_count [lhb_pkg::NUM_BUCKETS];
  logic [lhb_pkg::COUNT_WIDTH-1:0] ovf_count;
  logic [lhb_pkg::COUNT_WIDTH-1:0] obs_count;
  logic [lhb_pkg::VALUE_WIDTH-1:0] min_ns;
  logic [lhb_pkg::VALUE_WIDTH-1:0] max_ns;
  logic [lhb_pkg::SUM_WIDTH-1:0]   sum_ns;

  lhb_pkg::in_beat_t  pend_beats[$];
  lhb_pkg::out_beat_t hist_replies[$];
  logic               calm = 1'b0;
  logic               in_fire = 1'b0;
  int                 err_cnt = 0;
  int                 stall_cnt = 0;

  task automatic histo_clear();
    for (int k = 0; k < lhb_pkg::NUM_BUCKETS; k++) begin
      bin_count[k] = '0;
    end
    ovf_count = '0;
    obs_count = '0;
    min_ns    = '1;
    max_ns    = '0;
    sum_ns    = '0;
  endtask

  function automatic logic [lhb_pkg::COUNT_WIDTH-1:0] sat_inc(
      input logic [lhb_pkg::COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  task automatic histo_step(input lhb_pkg::in_beat_t b, output lhb_pkg::out_beat_t r);
    logic [lhb_pkg::HIT_WIDTH-1:0] hit;
    logic [lhb_pkg::SUM_WIDTH-1:0] v64;
    logic                          empty;
    r = '0;
    empty = (obs_count == '0);
    case (b.func)
      lhb_pkg::FUNC_OBSERVE: begin
        hit = lhb_pkg::HIT_OVERFLOW;
        // Scan from the top so the lowest matching bound wins.
        for (int k = lhb_pkg::NUM_BUCKETS - 1; k >= 0; k--) begin
          if (b.lat_ns <= BOUND_NS[k]) hit = lhb_pkg::HIT_WIDTH'(k);
        end
        if (hit == lhb_pkg::HIT_OVERFLOW) ovf_count = sat_inc(ovf_count);
        else bin_count[hit] = sat_inc(bin_count[hit]);
        obs_count = sat_inc(obs_count);
        if (b.lat_ns < min_ns) min_ns = b.lat_ns;
        if (b.lat_ns > max_ns) max_ns = b.lat_ns;
        v64 = lhb_pkg::SUM_WIDTH'(b.lat_ns);
        sum_ns = (sum_ns > ~v64) ? '1 : sum_ns + v64;
        r.bucket_hit = hit;
      end
      lhb_pkg::FUNC_READ: begin
        if (b.read_select < lhb_pkg::NUM_BUCKETS) begin
          r.read_data = lhb_pkg::DATA_WIDTH'(bin_count[b.read_select]);
        end else begin
          case (b.read_select)
            lhb_pkg::SEL_OVERFLOW: r.read_data = lhb_pkg::DATA_WIDTH'(ovf_count);
            lhb_pkg::SEL_COUNT:    r.read_data = lhb_pkg::DATA_WIDTH'(obs_count);
            lhb_pkg::SEL_MIN:      r.read_data = empty ? '0 : lhb_pkg::DATA_WIDTH'(min_ns);
            lhb_pkg::SEL_MAX:      r.read_data = empty ? '0 : lhb_pkg::DATA_WIDTH'(max_ns);
            lhb_pkg::SEL_SUM:      r.read_data = lhb_pkg::DATA_WIDTH'(sum_ns);
            default:               r.read_data = '0;
          endcase
        end
      end
      lhb_pkg::FUNC_CLEAR: histo_clear();
      default: ;
    endcase
  endtask

  // Driver: presents pending beats at the falling edge.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pend_beats.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
        in_data  <= pend_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= calm || ($urandom_range(99) >= 38);
  end

  // Monitor: predicts on each accepted input beat, checks each result beat.
  always @(posedge clk) begin
    lhb_pkg::out_beat_t want;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        histo_step(in_data, want);
        hist_replies = {hist_replies, want};
      end
      if (out_valid && out_ready) begin
        if (hist_replies.size() == 0) begin
          $display("%0t: unexpected result beat, actual hit %0d data %0h", $time,
                   out_data.bucket_hit, out_data.read_data);
          err_cnt++;
        end else begin
          want = hist_replies.pop_front();
          if (out_data.bucket_hit !== want.bucket_hit) begin
            $display("%0t: bucket_hit mismatch, expected %0d actual %0d", $time,
                     want.bucket_hit, out_data.bucket_hit);
            err_cnt++;
          end
          if (out_data.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %0h actual %0h", $time,
                     want.read_data, out_data.read_data);
            err_cnt++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL latency_histogram_binning");
        $finish;
      end
    end
  end

  function automatic lhb_pkg::in_beat_t mk_beat(input lhb_pkg::func_t f,
                                                input logic [lhb_pkg::VALUE_WIDTH-1:0] v,
                                                input logic [lhb_pkg::SEL_WIDTH-1:0] s);
    lhb_pkg::in_beat_t b;
    b.func        = f;
    b.lat_ns      = v;
    b.read_select = s;
    return b;
  endfunction

  // Mostly values inside a random bucket, plus bound edges and raw noise.
  function automatic logic [lhb_pkg::VALUE_WIDTH-1:0] pick_latency();
    int k;
    int r;
    logic [lhb_pkg::VALUE_WIDTH-1:0] lo;
    logic [lhb_pkg::VALUE_WIDTH-1:0] hi;
    r = $urandom_range(99);
    k = $urandom_range(lhb_pkg::NUM_BUCKETS);
    lo = (k == 0) ? '0 : BOUND_NS[k-1] + 1'b1;
    hi = (k == lhb_pkg::NUM_BUCKETS) ? '1 : BOUND_NS[k];
    if (r < 10) return $urandom;
    if (r < 15) return lo;
    if (r < 20) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic lhb_pkg::in_beat_t rand_beat();
    int r;
    logic [lhb_pkg::SEL_WIDTH-1:0] s;
    r = $urandom_range(999);
    s = ($urandom_range(99) < 85) ?
        lhb_pkg::SEL_WIDTH'($urandom_range(lhb_pkg::SEL_SUM)) :
        lhb_pkg::SEL_WIDTH'($urandom_range(2**lhb_pkg::SEL_WIDTH - 1));
    if (r < 8) return mk_beat(lhb_pkg::FUNC_CLEAR, $urandom, s);
    if (r < 20) return mk_beat(FUNC_SPARE, $urandom, s);
    if (r < 330) return mk_beat(lhb_pkg::FUNC_READ, $urandom, s);
    return mk_beat(lhb_pkg::FUNC_OBSERVE, pick_latency(), s);
  endfunction

  task automatic add_beat(input lhb_pkg::in_beat_t b);
    pend_beats = {pend_beats, b};
  endtask

  task automatic wait_drain();
    while (pend_beats.size() > 0 || in_valid || hist_replies.size() > 0) begin
      @(posedge clk);
    end
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      add_beat(rand_beat());
    end
  endtask

  initial begin
    histo_clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty reads, bound edges, every selector class, the spare code, clear.
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_MIN));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_MAX));
    add_beat(mk_beat(lhb_pkg::FUNC_OBSERVE, '0, '0));
    add_beat(mk_beat(lhb_pkg::FUNC_OBSERVE, BOUND_NS[0], '0));
    add_beat(mk_beat(lhb_pkg::FUNC_OBSERVE, BOUND_NS[0] + 1'b1, '1));
    add_beat(mk_beat(lhb_pkg::FUNC_OBSERVE, BOUND_NS[lhb_pkg::NUM_BUCKETS-1], '0));
    add_beat(mk_beat(lhb_pkg::FUNC_OBSERVE, BOUND_NS[lhb_pkg::NUM_BUCKETS-1] + 1'b1, '0));
    add_beat(mk_beat(lhb_pkg::FUNC_OBSERVE, '1, '1));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, '0));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '1, 5'd1));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_WIDTH'(lhb_pkg::NUM_BUCKETS - 1)));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_OVERFLOW));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_COUNT));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_MIN));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_MAX));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_SUM));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_SUM + 1'b1));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, '1));
    add_beat(mk_beat(FUNC_SPARE, '1, '1));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_COUNT));
    add_beat(mk_beat(lhb_pkg::FUNC_CLEAR, '1, '1));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_COUNT));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_MIN));
    add_beat(mk_beat(lhb_pkg::FUNC_READ, '0, lhb_pkg::SEL_SUM));
    // Hold off until every result of the directed part is back.
    wait_drain();

    queue_random(700);
    wait_drain();
    // A long stretch with both sides streaming every cycle.
    calm = 1'b1;
    queue_random(400);
    wait_drain();
    calm = 1'b0;
    queue_random(750);
    wait_drain();
    repeat (5) @(posedge clk);

    if (err_cnt == 0) begin
      $display("PASS latency_histogram_binning");
    end else begin
      $display("FAIL latency_histogram_binning");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lhb_pkg.sv
hw/rtl/lhb_cell.sv
hw/rtl/lhb_stats.sv
hw/rtl/latency_histogram_binning.sv
tb/tb.sv
